// ===== rtl/slab_slot_allocator_core_assert.svh =====
// assertion macros for the slab slot allocator
// used by slab_slot_allocator_core; expects signals named clock and reset in scope
`ifndef SLAB_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// consequence holds in the same cycle
`define SSA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slab slot allocator assertion failed");

// consequence holds in the next cycle
`define SSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slab slot allocator assertion failed");

`endif

// ===== rtl/ssa_pkg.sv =====
// shared widths, codes and interface types of the slab slot allocator
// no dependencies; used by every module of the block
package ssa_pkg;

   localparam int ADDR_W     = 18;
   localparam int PTR_W      = 19;
   localparam int SLOT_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int TDATA_W    = 24;
   localparam int LINK_DEPTH = 32768;
   localparam int LINK_AW    = 15;
   localparam int LINK_LSB   = 3;
   localparam int HDR_BYTES  = 8;
   localparam int ADDR_SPAN  = 262144;

   localparam int DEF_BLOCK_BYTES = 4096;
   localparam int DEF_NUM_BLOCKS  = 64;

   localparam logic [SLOT_W-1:0] SLOT_MIN   = 12'd8;
   localparam logic [SLOT_W-1:0] SLOT_MAX   = 12'd2048;
   localparam logic [SLOT_W-1:0] SLOT_RESET = 12'd8;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL_FREE = 2'd2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] body;
      logic [SLOT_W-1:0] size;
   } ssa_open_req_type;

   typedef struct packed {
      logic             done;
      logic [PTR_W-1:0] first;
   } ssa_open_rsp_type;

   function automatic logic [SLOT_W-1:0] eff_slot(input logic [SLOT_W-1:0] raw);
      logic [SLOT_W-1:0] sz;
      sz = raw;
      if (raw < SLOT_MIN) begin
         sz = SLOT_MIN;
      end else if (raw > SLOT_MAX) begin
         sz = SLOT_MAX;
      end
      return sz;
   endfunction

endpackage

// ===== rtl/ssa_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// depends on ssa_pkg for default sizes only
module ssa_ram #(
   parameter int WIDTH = ssa_pkg::ADDR_W,
   parameter int DEPTH = ssa_pkg::LINK_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssa_first_slot.sv =====
// first slot address of a newly opened block: body rounded up to a multiple of slot size
// bit-serial remainder, one address bit per cycle; depends on ssa_pkg
module ssa_first_slot (
   input  logic                      clock,
   input  logic                      reset,
   input  ssa_pkg::ssa_open_req_type open_req,
   output ssa_pkg::ssa_open_rsp_type open_rsp
);
   import ssa_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADDR_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [ADDR_W-1:0] body_ff, body_in;
   logic [SLOT_W-1:0] size_ff, size_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [SLOT_W:0]   trial;
   logic [SLOT_W:0]   diff;
   logic [SLOT_W-1:0] pad;

   always_comb begin
      trial   = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = trial - {1'b0, size_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      body_in = body_ff;
      size_in = size_ff;
      rem_in  = rem_ff;
      if (open_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = open_req.body;
         body_in = open_req.body;
         size_in = open_req.size;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, size_ff}) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
         quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      body_ff <= body_in;
      size_ff <= size_in;
      rem_ff  <= rem_in;
   end

   assign pad            = (rem_ff == '0) ? '0 : (size_ff - rem_ff);
   assign open_rsp.done  = done_ff;
   assign open_rsp.first = {1'b0, body_ff} + PTR_W'(pad);

endmodule

// ===== rtl/slab_slot_allocator_core.sv =====
// slab slot allocator top level: free list head, bump pointer, block opening, stream ports
// depends on ssa_pkg, ssa_ram, ssa_first_slot and slab_slot_allocator_core_assert.svh
//
//  channel | ports                     | payload
//  --------+---------------------------+------------------------------------------
//  req     | req_tvalid / req_tready   | tuser: action; tdata: address
//  rsp     | rsp_tvalid / rsp_tready   | tuser: status; tdata: slot_address
//  csr     | csr_valid  / csr_ready    | csr_data: slot_size
//
//  free and bump allocate go straight to ST_EMIT; a free-list pop first reads the link ram
//  opening a block waits in ST_OPEN for the bit-serial remainder of the first slot
//  one item is in flight at a time; req_tready drops from its transfer until the result
//  moves into the output register, which holds while rsp_tready is low
//  reset clears head, pointers and counters; the link ram is not cleared
`include "slab_slot_allocator_core_assert.svh"

module slab_slot_allocator_core #(
   parameter int BLOCK_BYTES = ssa_pkg::DEF_BLOCK_BYTES,
   parameter int NUM_BLOCKS  = ssa_pkg::DEF_NUM_BLOCKS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssa_pkg::TDATA_W-1:0]    req_tdata,   // [17:0] address
   input  logic [0:0]                     req_tuser,   // [0] action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssa_pkg::TDATA_W-1:0]    rsp_tdata,   // [17:0] slot_address
   output logic [ssa_pkg::STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssa_pkg::SLOT_W-1:0]     csr_data     // [11:0] slot_size
);
   import ssa_pkg::*;

   localparam int SPAN_BLOCKS = ADDR_SPAN / BLOCK_BYTES;
   localparam int MAX_BLOCKS  = (NUM_BLOCKS < SPAN_BLOCKS) ? NUM_BLOCKS : SPAN_BLOCKS;
   localparam int OPEN_W      = $clog2(MAX_BLOCKS + 1);
   localparam logic [OPEN_W-1:0] OPEN_MAX = OPEN_W'(MAX_BLOCKS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_OPEN,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]    bump_ff, bump_in;
   logic [PTR_W-1:0]    limit_ff, limit_in;
   logic [OPEN_W-1:0]   opened_ff, opened_in;
   logic [SLOT_W-1:0]   slot_size_ff, slot_size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic [SLOT_W-1:0]   sz;
   logic [PTR_W:0]      bump_sum;
   logic [PTR_W:0]      first_sum;
   logic                need_open;
   logic                can_open;
   logic                fits;
   logic                req_fire;
   logic                req_action;
   logic [ADDR_W-1:0]   req_addr;

   logic                ram_wr_en;
   logic [LINK_AW-1:0]  ram_wr_addr;
   logic                ram_rd_en;
   logic [LINK_AW-1:0]  ram_rd_addr;
   logic [ADDR_W-1:0]   ram_rd_data;

   ssa_open_req_type    open_req;
   ssa_open_rsp_type    open_rsp;

   ssa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (head_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ssa_first_slot u_first_slot (
      .clock    (clock),
      .reset    (reset),
      .open_req (open_req),
      .open_rsp (open_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign req_action = req_tuser[0];
   assign req_addr   = req_tdata[ADDR_W-1:0];

   assign sz        = eff_slot(slot_size_ff);
   assign bump_sum  = {1'b0, bump_ff} + (PTR_W + 1)'(sz);
   assign need_open = bump_sum > {1'b0, limit_ff};
   assign can_open  = opened_ff < OPEN_MAX;
   assign first_sum = {1'b0, open_rsp.first} + (PTR_W + 1)'(sz);
   assign fits      = first_sum <= {1'b0, limit_ff};

   assign ram_wr_addr = req_addr[LINK_LSB +: LINK_AW];
   assign ram_rd_addr = head_ff[LINK_LSB +: LINK_AW];

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      bump_in       = bump_ff;
      limit_in      = limit_ff;
      opened_in     = opened_ff;
      slot_size_in  = slot_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      open_req      = '0;

      if (csr_valid && csr_ready) begin
         slot_size_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_addr_in   = '0;
               res_status_in = STATUS_DONE;
               state_in      = ST_EMIT;
               if (req_action == ACTION_FREE) begin
                  if (req_addr == '0) begin
                     res_status_in = STATUS_NULL_FREE;
                  end else begin
                     ram_wr_en = 1'b1;
                     head_in   = req_addr;
                  end
               end else if (head_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  res_addr_in = head_ff;
                  state_in    = ST_POP;
               end else if (!need_open) begin
                  res_addr_in = bump_ff[ADDR_W-1:0];
                  bump_in     = bump_sum[PTR_W-1:0];
               end else if (can_open) begin
                  opened_in      = opened_ff + 1'b1;
                  limit_in       = limit_ff + PTR_W'(BLOCK_BYTES);
                  open_req.start = 1'b1;
                  open_req.body  = limit_ff[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);
                  open_req.size  = sz;
                  state_in       = ST_OPEN;
               end else begin
                  res_status_in = STATUS_EXHAUSTED;
               end
            end
         end
         ST_POP: begin
            head_in  = ram_rd_data;
            state_in = ST_EMIT;
         end
         ST_OPEN: begin
            if (open_rsp.done) begin
               state_in = ST_EMIT;
               if (fits) begin
                  res_addr_in   = open_rsp.first[ADDR_W-1:0];
                  res_status_in = STATUS_DONE;
                  bump_in       = first_sum[PTR_W-1:0];
               end else begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_EXHAUSTED;
                  bump_in       = open_rsp.first;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         bump_ff      <= '0;
         limit_ff     <= '0;
         opened_ff    <= '0;
         slot_size_ff <= SLOT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         bump_ff      <= bump_in;
         limit_ff     <= limit_in;
         opened_ff    <= opened_in;
         slot_size_ff <= slot_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - ADDR_W){1'b0}}, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

   `SSA_ASSERT_NEXT(a_busy_after_transfer, req_tvalid && req_tready, !req_tready)
   `SSA_ASSERT_NEXT(a_push_sets_head, req_tvalid && req_tready && req_tuser[0] == ACTION_FREE && req_tdata[ADDR_W-1:0] != '0, head_ff == $past(req_tdata[ADDR_W-1:0]))
   `SSA_ASSERT_SAME(a_exhausted_is_null, rsp_tvalid && rsp_tuser == STATUS_EXHAUSTED, rsp_tdata == '0)
   `SSA_ASSERT_SAME(a_open_counted, state_ff == ST_OPEN, opened_ff != '0 && opened_ff <= OPEN_MAX)
   `SSA_ASSERT_SAME(a_ram_one_access, ram_wr_en, !ram_rd_en)

endmodule
